@@ rtl/core/ptda_pkg.sv @@
// shared types, constants and a helper function of the packed ternary dot accumulator
`default_nettype none

package ptda_pkg;

	// word field widths
	localparam int ActW      = 8;
	localparam int CodeW     = 8;
	localparam int SumW      = 32;
	localparam int MaxTrits  = 5;
	localparam int TritsPerCode = 5;

	// one lane term spans -128..128, a group sum up to eight terms
	localparam int TermW = ActW + 1;
	localparam int GrpW  = TermW + 3;

	// floor(u / 3) for u < 256 as (u * 171) >> 9
	localparam int DigW       = CodeW;
	localparam int ProdW      = 2 * DigW;
	localparam int Recip3     = 171;
	localparam int RecipShift = 9;

	// decoded weight
	typedef enum logic [1:0] {
		TRIT_ZERO,
		TRIT_POS,
		TRIT_NEG
	} trit_t;

	// per-stage control that travels with a word
	typedef struct packed {
		logic valid;
		logic last;
	} ptda_ctl_t;

	// 3^n, evaluated at elaboration
	function automatic int pow3(input int n);
		int p;
		p = 1;
		for (int k = 0; k < n; k++) begin
			p = p * 3;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/ptda_in_if.sv @@
// input channel: five activations, packed weight byte and last flag
`default_nettype none

interface ptda_in_if;
	import ptda_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ActW-1:0]  act_0;
	logic signed [ActW-1:0]  act_1;
	logic signed [ActW-1:0]  act_2;
	logic signed [ActW-1:0]  act_3;
	logic signed [ActW-1:0]  act_4;
	logic signed [CodeW-1:0] weight_code;
	logic                    last_group;

	modport source (
		output valid, act_0, act_1, act_2, act_3, act_4, weight_code, last_group,
		input  ready
	);

	modport sink (
		input  valid, act_0, act_1, act_2, act_3, act_4, weight_code, last_group,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/ptda_out_if.sv @@
// output channel: accumulated dot product
`default_nettype none

interface ptda_out_if;
	import ptda_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [SumW-1:0] dot_sum;

	modport source (
		output valid, dot_sum,
		input  ready
	);

	modport sink (
		input  valid, dot_sum,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/ptda_decode.sv @@
// input stage: takes a word, decodes the packed weight byte into trits
`default_nettype none

module ptda_decode #(
	parameter int TRITS_PER_CODE = ptda_pkg::TritsPerCode
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ptda_in_if.sink                                in_ch,
	input  wire logic                              s2_ready,
	output ptda_pkg::trit_t                        trit_s1 [TRITS_PER_CODE],
	output logic signed [ptda_pkg::ActW-1:0]       act_s1  [TRITS_PER_CODE],
	output ptda_pkg::ptda_ctl_t                    ctl_s1
);
	import ptda_pkg::*;

	localparam int Half = (pow3(TRITS_PER_CODE) - 1) / 2;
	localparam logic signed [CodeW:0] HalfS = (CodeW+1)'(Half);

	logic signed [ActW-1:0]  act_in [MaxTrits];
	logic signed [CodeW:0]   code_ext;
	logic signed [CodeW:0]   offset;
	logic                    in_range;
	logic [1:0]              lsd [MaxTrits];
	trit_t                   trit_d [TRITS_PER_CODE];
	logic                    load;

	assign act_in[0] = in_ch.act_0;
	assign act_in[1] = in_ch.act_1;
	assign act_in[2] = in_ch.act_2;
	assign act_in[3] = in_ch.act_3;
	assign act_in[4] = in_ch.act_4;

	// stage 1 takes a word when empty or when stage 2 drains it
	assign load        = !ctl_s1.valid || s2_ready;
	assign in_ch.ready = load;

	// range check and offset to plain base 3
	assign code_ext = {in_ch.weight_code[CodeW-1], in_ch.weight_code};
	assign in_range = (code_ext <= HalfS) && (code_ext >= -HalfS);
	assign offset   = code_ext + HalfS;

	// base-3 digits, least significant first, via reciprocal multiply
	always_comb begin
		logic [DigW-1:0]  rem;
		logic [ProdW-1:0] prod;
		logic [DigW-1:0]  quo;
		logic [DigW-1:0]  dig;
		rem = offset[DigW-1:0];
		for (int j = 0; j < MaxTrits; j++) begin
			prod   = ProdW'(rem) * ProdW'(Recip3);
			quo    = DigW'(prod >> RecipShift);
			dig    = rem - quo - quo - quo;
			lsd[j] = dig[1:0];
			rem    = quo;
		end
	end

	// digit 2 adds, digit 0 subtracts; first trit is the most significant digit
	for (genvar t = 0; t < TRITS_PER_CODE; t++) begin : g_trit
		always_comb begin
			if (!in_range) begin
				trit_d[t] = TRIT_ZERO;
			end else begin
				case (lsd[TRITS_PER_CODE-1-t])
					2'd2:    trit_d[t] = TRIT_POS;
					2'd0:    trit_d[t] = TRIT_NEG;
					default: trit_d[t] = TRIT_ZERO;
				endcase
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (load) begin
			ctl_s1.valid <= in_ch.valid;
			ctl_s1.last  <= in_ch.last_group;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (load) begin
			for (int t = 0; t < TRITS_PER_CODE; t++) begin
				trit_s1[t] <= trit_d[t];
				act_s1[t]  <= act_in[t];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ptda_lane.sv @@
// one lane: applies a ternary weight to its activation
`default_nettype none

module ptda_lane (
	input  wire logic                               clk,
	input  wire logic                               load,
	input  wire ptda_pkg::trit_t                    trit,
	input  wire logic signed [ptda_pkg::ActW-1:0]   act,
	output logic signed [ptda_pkg::TermW-1:0]       term_s2
);
	import ptda_pkg::*;

	logic signed [TermW-1:0] act_ext;
	logic signed [TermW-1:0] term_d;

	assign act_ext = {act[ActW-1], act};

	// add, subtract or drop the activation
	always_comb begin
		case (trit)
			TRIT_POS: term_d = act_ext;
			TRIT_NEG: term_d = -act_ext;
			default:  term_d = '0;
		endcase
	end

	// stage 2 term register
	always_ff @(posedge clk) begin
		if (load) begin
			term_s2 <= term_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ptda_merge.sv @@
// merge stage: sums lane terms, accumulates and drives the output word
`default_nettype none

module ptda_merge #(
	parameter int TRITS_PER_CODE = ptda_pkg::TritsPerCode
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ptda_pkg::ptda_ctl_t                ctl_s1,
	input  wire logic signed [ptda_pkg::TermW-1:0]  term_s2 [TRITS_PER_CODE],
	output logic                                    s2_ready,
	ptda_out_if.source                              out_ch
);
	import ptda_pkg::*;

	ptda_ctl_t              ctl_s2;
	logic signed [GrpW-1:0] grp_sum;
	logic signed [SumW-1:0] acc_q;
	logic signed [SumW-1:0] acc_next;
	logic                   out_valid_q;
	logic signed [SumW-1:0] dot_q;
	logic                   fire;

	// a last word waits only while the output register is full and stalled
	assign fire     = ctl_s2.valid && !(ctl_s2.last && out_valid_q && !out_ch.ready);
	assign s2_ready = !ctl_s2.valid || fire;

	// group sum over the lanes
	always_comb begin
		grp_sum = '0;
		for (int i = 0; i < TRITS_PER_CODE; i++) begin
			grp_sum = grp_sum + GrpW'(term_s2[i]);
		end
	end

	assign acc_next = acc_q + SumW'(grp_sum);

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (s2_ready) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// accumulator, cleared after each emitted dot product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (fire) begin
			acc_q <= ctl_s2.last ? '0 : acc_next;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctl_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl_s2.last) begin
			dot_q <= acc_next;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.dot_sum = dot_q;

endmodule

`default_nettype wire

@@ rtl/core/packed_ternary_dot_accumulator.sv @@
// Packed ternary dot accumulator: top level.
// in_ch carries one word per group: five signed activations, a packed weight
// byte holding five balanced-ternary weights (first trit most significant)
// and a last_group flag. out_ch carries one dot_sum word per dot product.
// Both channels move a word when valid and ready are high at a clock edge.
// One word is taken every cycle while in_ch.ready stays high: a decode stage
// splits the weight byte into trits, one lane per trit applies its weight,
// and a merge stage adds the lane terms into a 32-bit accumulator that wraps.
// A last word's dot_sum is registered after the decode and lane term stages.
// A weight byte outside the representable range adds nothing to the sum.
// When out_ch stalls with a result pending, non-last words keep flowing in;
// the next last word holds in the merge stage and back-pressure then fills
// the decode stage before in_ch.ready drops.
// arst_n clears the pipeline, the pending output word and the accumulator.
`default_nettype none

module packed_ternary_dot_accumulator #(
	parameter int TRITS_PER_CODE = ptda_pkg::TritsPerCode
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ptda_in_if.sink    in_ch,
	ptda_out_if.source out_ch
);
	import ptda_pkg::*;

	trit_t                   trit_s1 [TRITS_PER_CODE];
	logic signed [ActW-1:0]  act_s1  [TRITS_PER_CODE];
	ptda_ctl_t               ctl_s1;
	logic signed [TermW-1:0] term_s2 [TRITS_PER_CODE];
	logic                    s2_ready;

	// trit decode
	ptda_decode #(
		.TRITS_PER_CODE(TRITS_PER_CODE)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.s2_ready (s2_ready),
		.trit_s1  (trit_s1),
		.act_s1   (act_s1),
		.ctl_s1   (ctl_s1)
	);

	// one lane per trit
	for (genvar t = 0; t < TRITS_PER_CODE; t++) begin : g_lane
		ptda_lane u_lane (
			.clk     (clk),
			.load    (s2_ready),
			.trit    (trit_s1[t]),
			.act     (act_s1[t]),
			.term_s2 (term_s2[t])
		);
	end

	// sum, accumulate, emit
	ptda_merge #(
		.TRITS_PER_CODE(TRITS_PER_CODE)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.term_s2  (term_s2),
		.s2_ready (s2_ready),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire
